// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/oahi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-address hash insert package
// Item types, field widths and codes shared by the hash table modules.
// ----------------------------------------------------------------------------
package oahi_pkg;

    localparam int KEY_W   = 16;
    localparam int SLOT_W  = 5;
    localparam int COLL_W  = 5;
    localparam int ENTRY_W = KEY_W + 1;  // occupied flag above the key

    localparam logic [COLL_W-1:0] COLL_MAX = 5'd31;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_QUAD   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
    } in_item_t;

    typedef struct packed {
        logic [COLL_W-1:0] collisions;
        logic [SLOT_W-1:0] placed_slot;
        logic              table_full;
        logic [KEY_W-1:0]  read_key;
        logic              read_occupied;
    } out_item_t;

endpackage

// ----- rtl/oahi_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module oahi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[addr] <= wdata;
        end
        rdata_reg <= store_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/oahi_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Home slot unit
// Reduces a key modulo the table size by a reciprocal multiply.
// ----------------------------------------------------------------------------
module oahi_hash #(
    parameter int TABLE_SIZE = 31
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [oahi_pkg::KEY_W-1:0]    key_in,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] rem
);

    import oahi_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int SHIFT   = KEY_W + IDX_W;
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << SHIFT) / 64'(TABLE_SIZE));
    localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE);

    logic [KEY_W-1:0]  key_s1_reg;
    logic [KEY_W-1:0]  quot_reg, quot_next;
    logic [IDX_W:0]    rem_est_reg, rem_est_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic              stage1_reg;
    logic              stage2_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  back;
    logic [KEY_W-1:0]  diff;
    logic [IDX_W:0]    rem_fix;

    // The rounded-down reciprocal gives a quotient that is exact or one short,
    // so the first remainder lies below twice the table size and one
    // conditional subtract finishes it.
    always_comb begin
        prod         = PROD_W'(key_in) * PROD_W'(RECIP);
        quot_next    = KEY_W'(prod >> SHIFT);
        back         = quot_reg * DIVISOR;
        diff         = key_s1_reg - back;
        rem_est_next = diff[IDX_W:0];
        if (rem_est_reg >= (IDX_W + 1)'(TABLE_SIZE)) begin
            rem_fix = rem_est_reg - (IDX_W + 1)'(TABLE_SIZE);
        end else begin
            rem_fix = rem_est_reg;
        end
        rem_next = rem_fix[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_s1_reg <= key_in;
            quot_reg   <= quot_next;
        end
        if (stage1_reg) begin
            rem_est_reg <= rem_est_next;
        end
        if (stage2_reg) begin
            rem_reg <= rem_next;
        end
        if (!aresetn) begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
            done_reg   <= stage2_reg;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/open_address_hash_insert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-address hash insert
// Hash table of keys with linear or quadratic probing, insert and slot read.
// ----------------------------------------------------------------------------
// After reset the block clears the slot memory one slot after another and
// holds s_ready low meanwhile; probe_mode may be written at any time but is
// meant to change only while the block is idle. One item is worked on at a
// time and s_ready is high only when the block is idle, but a finished result
// sits in the output register, so the next item can be taken while it waits.
// With the output register free, a read of a slot inside the table passes
// through the read-wait state to the done state before m_valid rises, and a
// read past the end of the table goes straight to done. An insert first
// reduces the key to its home slot in a three-stage unit that multiplies by
// the reciprocal of the table size, then probes the slot memory at one slot
// per cycle: the read for the next candidate is issued while the data of the
// current one is checked. An insert makes between 1 and TABLE_SIZE probes. A
// full table, or a quadratic sequence that misses every free slot, ends
// after TABLE_SIZE probes with table_full set and nothing written. Each
// memory entry holds an occupied flag above the key.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module open_address_hash_insert #(
    parameter int TABLE_SIZE = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  oahi_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output oahi_pkg::out_item_t m_data
);

    import oahi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);
    localparam logic [IDX_W-1:0] TWO_MOD  = IDX_W'(2 % TABLE_SIZE);
    localparam logic [COLL_W-1:0] FULL_COLL =
        (TABLE_SIZE > 31) ? COLL_MAX : COLL_W'(TABLE_SIZE);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    // Sum of two slot indexes, each below the table size, reduced once.
    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W + 1)'(TABLE_SIZE)) begin
            s = s - (IDX_W + 1)'(TABLE_SIZE);
        end
        return s[IDX_W-1:0];
    endfunction

    // Collision count saturated to the width of the result field.
    function automatic logic [COLL_W-1:0] sat_coll(input logic [IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'(COLL_MAX)) ? COLL_MAX : COLL_W'(v);
    endfunction

    state_t            state_reg, state_next;
    logic              probe_mode_reg, probe_mode_next;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    out_item_t         m_data_reg, m_data_next;
    out_item_t         res_reg, res_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]  home_reg, home_next;
    logic [IDX_W-1:0]  cur_idx_reg, cur_idx_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  sq_reg, sq_next;
    logic [IDX_W-1:0]  odd_reg, odd_next;
    logic              hash_go_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               slot_occ;
    logic [KEY_W-1:0]   slot_key;

    logic               hash_start;
    logic               hash_done;
    logic [IDX_W-1:0]   hash_rem;

    logic [IDX_W-1:0]   sq_step;
    logic [IDX_W-1:0]   lin_idx;
    logic [IDX_W-1:0]   quad_idx;
    logic [IDX_W-1:0]   nxt_idx;

    oahi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    oahi_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key_in  (key_reg),
        .done    (hash_done),
        .rem     (hash_rem)
    );

    assign slot_occ = ram_rdata[KEY_W];
    assign slot_key = ram_rdata[KEY_W-1:0];

    // Next candidate slot. In quadratic mode sq_reg holds p*p and odd_reg
    // holds 2p+1, both modulo the table size, for the probe p now checked.
    always_comb begin
        sq_step  = mod_add(sq_reg, odd_reg);
        quad_idx = mod_add(home_reg, sq_step);
        lin_idx  = (cur_idx_reg == LAST_IDX) ? '0 : cur_idx_reg + ONE_IDX;
        nxt_idx  = (probe_mode_reg == MODE_QUAD) ? quad_idx : lin_idx;
    end

    always_comb begin
        state_next      = state_reg;
        probe_mode_next = cfg_wr_en ? cfg_wr_data : probe_mode_reg;
        m_valid_next    = m_valid_reg;
        clr_idx_next    = clr_idx_reg;
        m_data_next     = m_data_reg;
        res_next        = res_reg;
        key_next        = key_reg;
        home_next       = home_reg;
        cur_idx_next    = cur_idx_reg;
        cnt_next        = cnt_reg;
        sq_next         = sq_reg;
        odd_next        = odd_reg;
        ram_we          = 1'b0;
        ram_addr        = '0;
        ram_wdata       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + ONE_IDX;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_data.key;
                    res_next = '0;
                    if (s_data.action == ACT_READ) begin
                        // Slots beyond the table read as empty without a lookup.
                        if (32'(s_data.slot) < 32'(TABLE_SIZE)) begin
                            ram_addr   = IDX_W'(s_data.slot);
                            state_next = ST_RD_WAIT;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    home_next    = hash_rem;
                    cur_idx_next = hash_rem;
                    cnt_next     = '0;
                    sq_next      = '0;
                    odd_next     = ONE_IDX;
                    ram_addr     = hash_rem;
                    state_next   = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!slot_occ) begin
                    ram_we               = 1'b1;
                    ram_addr             = cur_idx_reg;
                    ram_wdata            = {1'b1, key_reg};
                    res_next             = '0;
                    res_next.collisions  = sat_coll(cnt_reg);
                    res_next.placed_slot = SLOT_W'(cur_idx_reg);
                    state_next           = ST_DONE;
                end else if (cnt_reg == LAST_IDX) begin
                    res_next            = '0;
                    res_next.table_full = 1'b1;
                    res_next.collisions = FULL_COLL;
                    state_next          = ST_DONE;
                end else begin
                    ram_addr     = nxt_idx;
                    cur_idx_next = nxt_idx;
                    cnt_next     = cnt_reg + ONE_IDX;
                    sq_next      = sq_step;
                    odd_next     = mod_add(odd_reg, TWO_MOD);
                end
            end
            ST_RD_WAIT: begin
                res_next               = '0;
                res_next.read_occupied = slot_occ;
                res_next.read_key      = slot_occ ? slot_key : '0;
                state_next             = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        res_reg     <= res_next;
        key_reg     <= key_next;
        home_reg    <= home_next;
        cur_idx_reg <= cur_idx_next;
        cnt_reg     <= cnt_next;
        sq_reg      <= sq_next;
        odd_reg     <= odd_next;
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            probe_mode_reg <= MODE_LINEAR;
            m_valid_reg    <= 1'b0;
            clr_idx_reg    <= '0;
            hash_go_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            probe_mode_reg <= probe_mode_next;
            m_valid_reg    <= m_valid_next;
            clr_idx_reg    <= clr_idx_next;
            hash_go_reg    <= (state_reg != ST_HASH) && (state_next == ST_HASH);
        end
    end

    // The key lands in key_reg at acceptance, so the home slot unit starts in
    // the first cycle of the hash state.
    assign hash_start = hash_go_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, (state_reg == ST_PROBE) && ram_we, !slot_occ, "insert wrote over an occupied slot")
    `ASSERT_NEXT(a_write_gives_result, aclk, aresetn, (state_reg == ST_PROBE) && ram_we, (state_reg == ST_DONE) && !res_reg.table_full, "stored key without a placed result")
    `ASSERT_IMPLIES(a_home_in_range, aclk, aresetn, hash_done, 32'(hash_rem) < 32'(TABLE_SIZE), "home slot outside the table")
    `ASSERT_IMPLIES(a_hash_only_when_hashing, aclk, aresetn, hash_go_reg, state_reg == ST_HASH, "home slot unit started outside the hash state")

endmodule
